### rtl/bpps_pkg.sv
// shared types, constants and table functions of the blinn-phong pixel shader
package bpps_pkg;

  // field widths of the pixel and result beats
  localparam int POS_W  = 20;
  localparam int NRM_W  = 16;
  localparam int TEX_W  = 8;
  localparam int COL_W  = 16;
  localparam int SHD_W  = 16;
  localparam int SHIN_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3 * POS_W;
  localparam logic [SHIN_W-1:0] SHIN_RESET = 16'd8192;

  // vector normaliser widths
  localparam int NV_W   = POS_W + 1;
  localparam int MAG_W  = POS_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int LEN_W  = RAD_W / 2;
  localparam int REM_W  = LEN_W + 2;
  localparam int FRAC_W = 14;
  localparam int QUO_W  = FRAC_W + 1;
  localparam int UNIT_W = FRAC_W + 2;
  localparam int DIVR_W = MAG_W + QUO_W;

  // register stages of one normaliser and of the whole datapath
  localparam int NORM_LAT = 3 + LEN_W + 1 + QUO_W + 1;
  localparam int PIPE_LAT = 2 * NORM_LAT + 14;

  // fixed-point constants
  localparam logic [QUO_W-1:0] ONE_Q14    = 15'd16384;
  localparam logic [SHD_W-1:0] SHADE_ONE  = 16'd32768;
  localparam logic [36:0]      SAT_LIMIT  = 37'd8356095;
  localparam logic [24:0]      RECIP_255  = 25'd16843010;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA    = 3'd0,
    CFG_LIGHT_POS = 3'd1,
    CFG_LIGHT_COL = 3'd2,
    CFG_AMBIENT   = 3'd3,
    CFG_DIFFUSE   = 3'd4,
    CFG_SPECULAR  = 3'd5,
    CFG_SHININESS = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] frag_pos_x;
    logic signed [POS_W-1:0] frag_pos_y;
    logic signed [POS_W-1:0] frag_pos_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [TEX_W-1:0]        texel_r;
    logic [TEX_W-1:0]        texel_g;
    logic [TEX_W-1:0]        texel_b;
  } pixel_t;

  typedef struct packed {
    logic [SHD_W-1:0] shade_r;
    logic [SHD_W-1:0] shade_g;
    logic [SHD_W-1:0] shade_b;
  } shade_t;

  typedef logic signed [NV_W-1:0]   nval_t;
  typedef nval_t [2:0]              nvec_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef unit_t [2:0]              uvec_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [RAD_W-1:0]      rad;
    logic [LEN_W-1:0]      root;
    logic [REM_W-1:0]      rem;
  } sqrt_stage_t;

  typedef struct packed {
    logic [2:0]             neg;
    logic                   zero;
    logic [LEN_W-1:0]       len;
    logic [2:0][DIVR_W-1:0] rem;
    logic [2:0][QUO_W-1:0]  quo;
  } div_stage_t;

  // integer square root, truncating
  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rest;
    logic [63:0] res;
    logic [63:0] bit_v;
    rest  = n;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rest >= res + bit_v) begin
        rest = rest - (res + bit_v);
        res  = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/2^a) in q16, by repeated squaring of a q30 mantissa
  function automatic logic [15:0] pow_log_entry(input int a, input int i);
    logic [63:0] y;
    logic [63:0] r;
    y = (64'(1 << a) + 64'(i)) << (30 - a);
    r = '0;
    for (int k = 1; k <= 20; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        r = r | (64'd1 << (20 - k));
      end
    end
    return 16'((r + 64'd8) >> 4);
  endfunction

  // 2^(i/2^a) in q14, product of the roots 2^(2^-m)
  function automatic logic [15:0] pow_exp_entry(input int a, input int i);
    logic [63:0] root [13];
    logic [63:0] u;
    logic [63:0] v;
    root[0] = '0;
    root[1] = isqrt64(64'd1 << 61);
    for (int m = 2; m <= 12; m++) root[m] = isqrt64(root[m-1] << 30);
    u = 64'(i) << (12 - a);
    v = 64'd1 << 30;
    for (int m = 1; m <= 12; m++) begin
      if (u[12-m]) v = (v * root[m]) >> 30;
    end
    return 16'((v + 64'd32768) >> 16);
  endfunction

endpackage

### rtl/bpps_norm.sv
// pipelined vector normaliser: sum of squares, square root, per-component division
module bpps_norm
  import bpps_pkg::*;
(
  input  logic  clk_i,
  input  nvec_t vec_i,
  output uvec_t unit_o
);

  localparam int WIDE_W = REM_W + 2;

  logic [2:0][MAG_W-1:0] mag_a_q, mag_b_q;
  logic [2:0]            neg_a_q, neg_b_q;
  logic [2:0][SQ_W-1:0]  sq_b_q;
  sqrt_stage_t           sqs_q [LEN_W+1];
  div_stage_t            dvs_q [QUO_W+1];
  uvec_t                 unit_q;

  // magnitude and sign of each component
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      neg_a_q[c] <= vec_i[c][NV_W-1];
      mag_a_q[c] <= vec_i[c][NV_W-1] ? MAG_W'(-vec_i[c]) : MAG_W'(vec_i[c]);
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    mag_b_q <= mag_a_q;
    neg_b_q <= neg_a_q;
    for (int c = 0; c < 3; c++) begin
      sq_b_q[c] <= mag_a_q[c] * mag_a_q[c];
    end
  end

  // sum of squares enters the root pipeline
  always_ff @(posedge clk_i) begin
    sqs_q[0].mag  <= mag_b_q;
    sqs_q[0].neg  <= neg_b_q;
    sqs_q[0].rad  <= RAD_W'(sq_b_q[0]) + RAD_W'(sq_b_q[1]) + RAD_W'(sq_b_q[2]);
    sqs_q[0].root <= '0;
    sqs_q[0].rem  <= '0;
  end

  // square root, one result bit per stage
  for (genvar k = 1; k <= LEN_W; k++) begin : g_sqrt
    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] trial;
    sqrt_stage_t       step_d;

    always_comb begin
      step_d     = sqs_q[k-1];
      wide       = {sqs_q[k-1].rem, sqs_q[k-1].rad[RAD_W-1 -: 2]};
      trial      = WIDE_W'({sqs_q[k-1].root, 2'b01});
      step_d.rad = sqs_q[k-1].rad << 2;
      if (wide >= trial) begin
        step_d.rem  = REM_W'(wide - trial);
        step_d.root = {sqs_q[k-1].root[LEN_W-2:0], 1'b1};
      end else begin
        step_d.rem  = wide[REM_W-1:0];
        step_d.root = {sqs_q[k-1].root[LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      sqs_q[k] <= step_d;
    end
  end

  // dividends with half the length added for rounding
  always_ff @(posedge clk_i) begin
    dvs_q[0].neg  <= sqs_q[LEN_W].neg;
    dvs_q[0].zero <= (sqs_q[LEN_W].root == '0);
    dvs_q[0].len  <= sqs_q[LEN_W].root;
    dvs_q[0].quo  <= '0;
    for (int c = 0; c < 3; c++) begin
      dvs_q[0].rem[c] <= (DIVR_W'(sqs_q[LEN_W].mag[c]) << FRAC_W)
                       + DIVR_W'(sqs_q[LEN_W].root >> 1);
    end
  end

  // restoring division, one quotient bit per stage for all three components
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    localparam int QB = QUO_W - k;
    logic [DIVR_W-1:0] dsr;
    div_stage_t        step_d;

    always_comb begin
      step_d = dvs_q[k-1];
      dsr    = DIVR_W'(dvs_q[k-1].len) << QB;
      for (int c = 0; c < 3; c++) begin
        if (dvs_q[k-1].rem[c] >= dsr) begin
          step_d.rem[c]     = dvs_q[k-1].rem[c] - dsr;
          step_d.quo[c][QB] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dvs_q[k] <= step_d;
    end
  end

  // restore signs, zero-length vectors give the zero vector
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (dvs_q[QUO_W].zero) begin
        unit_q[c] <= '0;
      end else if (dvs_q[QUO_W].neg[c]) begin
        unit_q[c] <= -UNIT_W'(dvs_q[QUO_W].quo[c]);
      end else begin
        unit_q[c] <= UNIT_W'(dvs_q[QUO_W].quo[c]);
      end
    end
  end

  assign unit_o = unit_q;

endmodule

### rtl/blinn_phong_pixel_shader_unit.sv
// blinn-phong pixel shader, one point light, one pixel per clock
//
// Pixel beats enter on pixel_i when start is high; busy stays low, so a new
// pixel is taken in every cycle. Each pixel gives exactly one shade beat on
// shade_o, marked by done_o for one cycle. Throughput is one pixel per
// cycle; the latency is set by the two normalisers in series (41 stages
// each: root and divider one bit a stage) plus the dot, power and colour
// stages.
// Configuration beats go in on cfg_valid_i/cfg_index_i/cfg_data_i and are
// always taken (cfg_ready_o high); an index past the list is ignored. Write
// them only while no pixel is in flight.
// Reset clears the pipeline valid bits and loads the register defaults
// (shininess 32.0, all else zero). Results cannot be held off: done_o is a
// strobe and the shade value is present for that cycle only.
module blinn_phong_pixel_shader_unit
  import bpps_pkg::*;
#(
  parameter int POW_TABLE_ADDR_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pixel_t                pixel_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output shade_t                shade_o
);

  localparam int TAB_SIZE = 1 << POW_TABLE_ADDR_BITS;
  localparam int IDX_HOUT = 2 * NORM_LAT + 1;
  localparam int TEX_LEN  = IDX_HOUT + 11;
  localparam int A_W      = POW_TABLE_ADDR_BITS;

  // configuration registers
  logic [3*POS_W-1:0] cam_q, lpos_q;
  logic [3*COL_W-1:0] lcol_q, acol_q, dcol_q, scol_q;
  logic [SHIN_W-1:0]  shin_q;

  // pipeline
  logic [PIPE_LAT-1:0]     vld_q;
  logic [2:0][TEX_W-1:0]   tex_q [TEX_LEN];
  nvec_t                   nrm0_q, lgt0_q, view0_q;
  nvec_t                   nrm0_d, lgt0_d, view0_d;
  logic signed [POS_W-1:0] pos [3];
  uvec_t                   nrm_u, lgt_u, view_u, half_u;
  uvec_t                   nrm1_q, lgt1_q;
  nvec_t                   half1_q;
  uvec_t                   nrm_dly_q [NORM_LAT];
  uvec_t                   lgt_dly_q [NORM_LAT];
  logic signed [31:0]      pnl_q [3];
  logic signed [31:0]      pnh_q [3];
  logic [QUO_W-1:0]        diff2_q, base2_q, diff3_q, diff4_q, diff5_q, diff6_q;
  logic [3:0]              lead_d, lead3_q;
  logic [QUO_W-1:0]        xn_d;
  logic [A_W-1:0]          idx3_q;
  logic                    zero3_q, zero4_q, zero5_q;
  logic [19:0]             nlog4_q;
  logic [35:0]             epow_d;
  logic [27:0]             expo5_q;
  logic [11:0]             eint_d;
  logic [15:0]             efrac_d, fneg_d;
  logic [QUO_W-1:0]        spec_d, spec6_q, spec7_q;
  logic [15:0]             log_tab [TAB_SIZE];
  logic [15:0]             exp_tab [TAB_SIZE];
  logic [2:0][30:0]        ldf_d;
  logic [2:0][46:0]        lsp_d;
  logic [2:0][31:0]        ls7_q;
  logic [2:0][15:0]        df7_q, df8_q;
  logic [2:0][20:0]        sp8_q;
  logic [2:0][21:0]        sum9_q;
  logic [2:0][37:0]        m10_q;
  logic [2:0][45:0]        m11_q;
  logic [2:0][36:0]        y_d;
  logic [2:0][47:0]        rec_d;
  logic [2:0][SHD_W-1:0]   shd_d;
  shade_t                  shade_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // power tables, fixed at elaboration
  for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
    assign log_tab[g] = pow_log_entry(POW_TABLE_ADDR_BITS, g);
    assign exp_tab[g] = pow_exp_entry(POW_TABLE_ADDR_BITS, g);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q  <= '0;
      lpos_q <= '0;
      lcol_q <= '0;
      acol_q <= '0;
      dcol_q <= '0;
      scol_q <= '0;
      shin_q <= SHIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAMERA:    cam_q  <= cfg_data_i;
        CFG_LIGHT_POS: lpos_q <= cfg_data_i;
        CFG_LIGHT_COL: lcol_q <= cfg_data_i[3*COL_W-1:0];
        CFG_AMBIENT:   acol_q <= cfg_data_i[3*COL_W-1:0];
        CFG_DIFFUSE:   dcol_q <= cfg_data_i[3*COL_W-1:0];
        CFG_SPECULAR:  scol_q <= cfg_data_i[3*COL_W-1:0];
        CFG_SHININESS: shin_q <= cfg_data_i[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], start & ~busy};
    end
  end

  // texels ride along until the colour multiply
  always_ff @(posedge clk_i) begin
    tex_q[0] <= {pixel_i.texel_b, pixel_i.texel_g, pixel_i.texel_r};
    for (int i = 1; i < TEX_LEN; i++) tex_q[i] <= tex_q[i-1];
  end

  // input stage: normal, light and view vectors
  assign pos[0] = pixel_i.frag_pos_x;
  assign pos[1] = pixel_i.frag_pos_y;
  assign pos[2] = pixel_i.frag_pos_z;

  always_comb begin
    nrm0_d[0] = NV_W'(pixel_i.normal_x);
    nrm0_d[1] = NV_W'(pixel_i.normal_y);
    nrm0_d[2] = NV_W'(pixel_i.normal_z);
    for (int c = 0; c < 3; c++) begin
      lgt0_d[c]  = NV_W'($signed(lpos_q[POS_W*c +: POS_W])) - NV_W'(pos[c]);
      view0_d[c] = NV_W'($signed(cam_q[POS_W*c +: POS_W])) - NV_W'(pos[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    nrm0_q  <= nrm0_d;
    lgt0_q  <= lgt0_d;
    view0_q <= view0_d;
  end

  bpps_norm u_norm_n (.clk_i(clk_i), .vec_i(nrm0_q),  .unit_o(nrm_u));
  bpps_norm u_norm_l (.clk_i(clk_i), .vec_i(lgt0_q),  .unit_o(lgt_u));
  bpps_norm u_norm_v (.clk_i(clk_i), .vec_i(view0_q), .unit_o(view_u));

  // half vector
  always_ff @(posedge clk_i) begin
    nrm1_q <= nrm_u;
    lgt1_q <= lgt_u;
    for (int c = 0; c < 3; c++) begin
      half1_q[c] <= NV_W'(lgt_u[c]) + NV_W'(view_u[c]);
    end
  end

  bpps_norm u_norm_h (.clk_i(clk_i), .vec_i(half1_q), .unit_o(half_u));

  // n and l wait for the half vector
  always_ff @(posedge clk_i) begin
    nrm_dly_q[0] <= nrm1_q;
    lgt_dly_q[0] <= lgt1_q;
    for (int i = 1; i < NORM_LAT; i++) begin
      nrm_dly_q[i] <= nrm_dly_q[i-1];
      lgt_dly_q[i] <= lgt_dly_q[i-1];
    end
  end

  // clamped positive dot product, q1.14
  function automatic logic [QUO_W-1:0] dot_clamp(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] c);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b) + 34'(c);
    if (s <= 0) return '0;
    if ((s >>> FRAC_W) > 34'sd16384) return ONE_Q14;
    return s[FRAC_W +: QUO_W];
  endfunction

  // dot products: component products, then sums
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      pnl_q[c] <= nrm_dly_q[NORM_LAT-1][c] * lgt_dly_q[NORM_LAT-1][c];
      pnh_q[c] <= nrm_dly_q[NORM_LAT-1][c] * half_u[c];
    end
    diff2_q <= dot_clamp(pnl_q[0], pnl_q[1], pnl_q[2]);
    base2_q <= dot_clamp(pnh_q[0], pnh_q[1], pnh_q[2]);
  end

  // leading one and log table address of the specular base
  always_comb begin
    lead_d = '0;
    for (int b = 0; b < QUO_W; b++) begin
      if (base2_q[b]) lead_d = 4'(b);
    end
    xn_d = base2_q << (4'd14 - lead_d);
  end

  always_ff @(posedge clk_i) begin
    lead3_q <= lead_d;
    idx3_q  <= xn_d[FRAC_W-1 -: A_W];
    zero3_q <= (base2_q == '0);
    diff3_q <= diff2_q;
  end

  // negative log2 of the base, q16
  always_ff @(posedge clk_i) begin
    nlog4_q <= {4'd14 - lead3_q, 16'h0000} - {4'h0, log_tab[idx3_q]};
    zero4_q <= zero3_q;
    diff4_q <= diff3_q;
  end

  // scale by the exponent
  assign epow_d = nlog4_q * shin_q;

  always_ff @(posedge clk_i) begin
    expo5_q <= epow_d[35:8];
    zero5_q <= zero4_q;
    diff5_q <= diff4_q;
  end

  // exp2 of the negated product
  always_comb begin
    eint_d  = expo5_q[27:16];
    efrac_d = expo5_q[15:0];
    fneg_d  = 16'(17'h10000 - 17'(efrac_d));
    if (shin_q == '0) begin
      spec_d = ONE_Q14;
    end else if (zero5_q) begin
      spec_d = '0;
    end else if (efrac_d == '0) begin
      spec_d = (eint_d >= 12'd15) ? '0 : (ONE_Q14 >> eint_d);
    end else if (eint_d >= 12'd15) begin
      spec_d = '0;
    end else begin
      spec_d = QUO_W'(exp_tab[fneg_d[15 -: A_W]] >> (eint_d[3:0] + 4'd1));
    end
  end

  always_ff @(posedge clk_i) begin
    spec6_q <= spec_d;
    diff6_q <= diff5_q;
  end

  // colour products per channel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ldf_d[c] = lcol_q[COL_W*c +: COL_W] * diff6_q;
      lsp_d[c] = ls7_q[c] * spec7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    spec7_q <= spec6_q;
    for (int c = 0; c < 3; c++) begin
      ls7_q[c]  <= lcol_q[COL_W*c +: COL_W] * scol_q[COL_W*c +: COL_W];
      df7_q[c]  <= ldf_d[c][29:14];
      sp8_q[c]  <= lsp_d[c][46:26];
      df8_q[c]  <= df7_q[c];
      sum9_q[c] <= sp8_q[c] + acol_q[COL_W*c +: COL_W] + df8_q[c];
      m10_q[c]  <= sum9_q[c] * dcol_q[COL_W*c +: COL_W];
      m11_q[c]  <= m10_q[c] * tex_q[TEX_LEN-1][c];
    end
  end

  // divide by 255*512 and saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      y_d[c]   = m11_q[c][45:9];
      rec_d[c] = y_d[c][22:0] * RECIP_255;
      shd_d[c] = (y_d[c] >= SAT_LIMIT) ? SHADE_ONE : rec_d[c][47:32];
    end
  end

  always_ff @(posedge clk_i) begin
    shade_q.shade_r <= shd_d[0];
    shade_q.shade_g <= shd_d[1];
    shade_q.shade_b <= shd_d[2];
  end

  assign shade_o = shade_q;
  assign done_o  = vld_q[PIPE_LAT-1];

`ifndef SYNTHESIS
  a_shade_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (shade_o.shade_r <= SHADE_ONE && shade_o.shade_g <= SHADE_ONE &&
                shade_o.shade_b <= SHADE_ONE))
    else $error("shade above 1.0");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, PIPE_LAT))
    else $error("result beat without a pixel beat");

  a_spec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_HOUT+6] |-> (spec6_q <= ONE_Q14))
    else $error("specular term above 1.0");

  a_diff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IDX_HOUT+2] |-> (diff2_q <= ONE_Q14 && base2_q <= ONE_Q14))
    else $error("dot product above 1.0");
`endif

endmodule
